// File: hdl/ubds_pkg.sv
// Shared types and constants for the UART baud divisor search.
`timescale 1ns / 1ps
`default_nettype none
package ubds_pkg;

  localparam int unsigned ClkW      = 30;
  localparam int unsigned BaudW     = 24;
  localparam int unsigned GenW      = 16;
  localparam int unsigned DivW      = 8;
  localparam int unsigned SpanW     = 32;
  localparam int unsigned ProdW     = GenW + DivW;

  localparam logic [ClkW-1:0] RefClkReset = 30'd50000000;
  localparam int unsigned BdivLimitDef    = 255;
  localparam int unsigned BgenMaxDef      = 65535;
  localparam logic [DivW-1:0] BdivFirst   = 8'd4;
  localparam logic [GenW-1:0] BgenMin     = 16'd2;

  // One queued request between the front and the back.
  typedef struct packed {
    logic [BaudW-1:0] target;
    logic             zero;
  } req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_CHK,
    S_DIV1,
    S_MUL2,
    S_START2,
    S_DIV2,
    S_NEXT,
    S_OUT
  } search_state_e;

endpackage : ubds_pkg
`default_nettype wire

// File: hdl/uart_baud_divisor_search.sv
// Top level of the UART baud divisor search.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  request  | push / full        | target_baud_i
//  result   | empty / pop        | clock_gen_divisor_o, bit_divider_o,
//           |                    | rate_error_o, found_o
//  config   | ref_clock_we_i     | ref_clock_hz_i
//
// For each bit divider a request is either skipped by the span check, stopped after
// the first serial division where the quotient is out of range, or needs both serial
// divisions; a zero target goes straight to the result once the back takes it.
// Two requests queue in the front while the back searches; a finished result
// waits in the output register and stalls the back only when the next is done.
// Reset empties the queue and result, clears search state; ref clock resets to 50 MHz.
`timescale 1ns / 1ps
`default_nettype none
module uart_baud_divisor_search
  import ubds_pkg::*;
#(
  parameter int unsigned BDIV_LIMIT = BdivLimitDef,
  parameter int unsigned BGEN_MAX   = BgenMaxDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             ref_clock_we_i,
  input  wire logic [ClkW-1:0]  ref_clock_hz_i,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [BaudW-1:0] target_baud_i,
  output logic                  empty,
  input  wire logic             pop,
  output logic [GenW-1:0]       clock_gen_divisor_o,
  output logic [DivW-1:0]       bit_divider_o,
  output logic [BaudW-1:0]      rate_error_o,
  output logic                  found_o
);

  logic [ClkW-1:0] ref_clk_q;
  logic            q_valid, q_deq;
  req_t            q_req;

  // Hold the reference clock register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ref_clk_q <= RefClkReset;
    else if (ref_clock_we_i) ref_clk_q <= ref_clock_hz_i;
  end

  ubds_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .target_baud_i (target_baud_i),
    .q_valid_o     (q_valid),
    .q_req_o       (q_req),
    .q_deq_i       (q_deq)
  );

  ubds_back #(
    .BDIV_LIMIT (BDIV_LIMIT),
    .BGEN_MAX   (BGEN_MAX)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .ref_clk_i           (ref_clk_q),
    .q_valid_i           (q_valid),
    .q_req_i             (q_req),
    .q_deq_o             (q_deq),
    .empty               (empty),
    .pop                 (pop),
    .clock_gen_divisor_o (clock_gen_divisor_o),
    .bit_divider_o       (bit_divider_o),
    .rate_error_o        (rate_error_o),
    .found_o             (found_o)
  );

endmodule : uart_baud_divisor_search
`default_nettype wire

// File: hdl/ubds_front.sv
// Front end: accepts requests, flags a zero target and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none
module ubds_front
  import ubds_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [BaudW-1:0] target_baud_i,
  output logic                  q_valid_o,
  output req_t                  q_req_o,
  input  wire logic             q_deq_i
);

  req_t        entry_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;
  logic        enq;
  logic        deq;

  assign full      = (count_q == 2'd2);
  assign enq       = push && !full;
  assign q_valid_o = (count_q != 2'd0);
  assign deq       = q_deq_i && q_valid_o;
  assign q_req_o   = entry_q[rd_ptr_q];

  // Store the request together with its zero-target class
  always_ff @(posedge clk_i) begin
    if (enq) begin
      entry_q[wr_ptr_q].target <= target_baud_i;
      entry_q[wr_ptr_q].zero   <= (target_baud_i == '0);
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (enq) wr_ptr_q <= ~wr_ptr_q;
      if (deq) rd_ptr_q <= ~rd_ptr_q;
      case ({enq, deq})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule : ubds_front
`default_nettype wire

// File: hdl/ubds_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ubds_div
  import ubds_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [ClkW-1:0]  dividend_i,
  input  wire logic [SpanW-1:0] divisor_i,
  output logic                  done_o,
  output logic [ClkW-1:0]       quotient_o
);

  logic [SpanW-1:0] dsr_q;
  logic [SpanW-1:0] rem_q;
  logic [ClkW-1:0]  quo_q;
  logic [4:0]       cnt_q;
  logic             busy_q, done_q;
  logic [SpanW:0]   shifted;
  logic             fits;

  assign shifted    = {rem_q, quo_q[ClkW-1]};
  assign fits       = (shifted >= {1'b0, dsr_q});
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  // Shift in one dividend bit and subtract where the divisor fits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dsr_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? SpanW'(shifted - {1'b0, dsr_q}) : shifted[SpanW-1:0];
      quo_q <= {quo_q[ClkW-2:0], fits};
    end
  end

  // Count the steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(ClkW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule : ubds_div
`default_nettype wire

// File: hdl/ubds_back.sv
// Back end: steps through the bit dividers, keeps the best pair and holds the result.
`timescale 1ns / 1ps
`default_nettype none
module ubds_back
  import ubds_pkg::*;
#(
  parameter int unsigned BDIV_LIMIT = BdivLimitDef,
  parameter int unsigned BGEN_MAX   = BgenMaxDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [ClkW-1:0]  ref_clk_i,
  input  wire logic             q_valid_i,
  input  wire req_t             q_req_i,
  output logic                  q_deq_o,
  output logic                  empty,
  input  wire logic             pop,
  output logic [GenW-1:0]       clock_gen_divisor_o,
  output logic [DivW-1:0]       bit_divider_o,
  output logic [BaudW-1:0]      rate_error_o,
  output logic                  found_o
);

  search_state_e    state_q, state_d;
  logic [BaudW-1:0] target_q;
  logic [DivW-1:0]  bdiv_q;
  logic [SpanW-1:0] span_q;
  logic [ClkW-1:0]  gen_q;
  logic [ProdW-1:0] prod_q;
  logic [BaudW-1:0] best_err_q;
  logic [GenW-1:0]  best_gen_q;
  logic [DivW-1:0]  best_div_q;
  logic             hit_q;
  logic             res_valid_q;
  logic [GenW-1:0]  res_gen_q;
  logic [DivW-1:0]  res_div_q;
  logic [BaudW-1:0] res_err_q;
  logic             res_found_q;

  logic             div_start, div_done, res_load, last_div, span_ok, gen_ok;
  logic [ClkW-1:0]  quo;
  logic [SpanW-1:0] divisor;
  logic [ClkW-1:0]  err;
  logic [DivW:0]    bdiv_p1;

  assign bdiv_p1  = {1'b0, bdiv_q} + 9'd1;
  assign last_div = (bdiv_q == DivW'(BDIV_LIMIT - 1));
  // Quotient is at least two when twice the span fits in the clock
  assign span_ok  = ({span_q, 1'b0} <= {3'b0, ref_clk_i});
  assign gen_ok   = (gen_q >= ClkW'(BgenMin)) && (gen_q <= ClkW'(BGEN_MAX));
  assign divisor  = (state_q == S_CHK) ? span_q : SpanW'(prod_q);
  assign err      = (quo > ClkW'(target_q)) ? quo - ClkW'(target_q)
                                            : ClkW'(target_q) - quo;

  ubds_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (ref_clk_i),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (q_valid_i) state_d = q_req_i.zero ? S_OUT : S_MUL1;
      S_MUL1:   state_d = S_CHK;
      S_CHK:    state_d = span_ok ? S_DIV1 : S_NEXT;
      S_DIV1:   if (div_done) state_d = S_MUL2;
      S_MUL2:   state_d = gen_ok ? S_START2 : S_NEXT;
      S_START2: state_d = S_DIV2;
      S_DIV2:   if (div_done) state_d = S_NEXT;
      S_NEXT:   state_d = last_div ? S_OUT : S_MUL1;
      S_OUT:    if (!res_valid_q) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_deq_o   = 1'b0;
    div_start = 1'b0;
    res_load  = 1'b0;
    case (state_q)
      S_IDLE:   q_deq_o   = q_valid_i;
      S_CHK:    div_start = span_ok;
      S_START2: div_start = 1'b1;
      S_OUT:    res_load  = !res_valid_q;
      default:  ;
    endcase
  end

  // Datapath of the search
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        target_q   <= q_req_i.target;
        bdiv_q     <= BdivFirst;
        best_err_q <= q_req_i.target;
        best_gen_q <= BgenMin;
        best_div_q <= BdivFirst;
        hit_q      <= 1'b0;
      end
      S_MUL1: span_q <= SpanW'(target_q * bdiv_p1);
      S_DIV1: if (div_done) gen_q <= quo;
      S_MUL2: prod_q <= ProdW'(gen_q[GenW-1:0] * bdiv_p1);
      S_DIV2: begin
        // Keep the first pair with a strictly smaller error
        if (div_done && (err < ClkW'(best_err_q))) begin
          best_err_q <= err[BaudW-1:0];
          best_gen_q <= gen_q[GenW-1:0];
          best_div_q <= bdiv_q;
          hit_q      <= 1'b1;
        end
      end
      S_NEXT: bdiv_q <= bdiv_q + 8'd1;
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_gen_q   <= best_gen_q;
      res_div_q   <= best_div_q;
      res_err_q   <= best_err_q;
      res_found_q <= hit_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_load) res_valid_q <= 1'b1;
      else if (pop) res_valid_q <= 1'b0;
    end
  end

  assign empty               = !res_valid_q;
  assign clock_gen_divisor_o = res_gen_q;
  assign bit_divider_o       = res_div_q;
  assign rate_error_o        = res_err_q;
  assign found_o             = res_found_q;

`ifndef SYNTHESIS
  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> !res_valid_q) else $error("result overwritten");
  a_div_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (state_q == S_DIV1) || (state_q == S_DIV2))
    else $error("divider started outside a wait state");
  a_found_err : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && hit_q) |-> (best_err_q < target_q))
    else $error("found without improvement");
  a_deq_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_deq_o |=> (state_q == S_MUL1) || (state_q == S_OUT))
    else $error("request taken without starting");
`endif

endmodule : ubds_back
`default_nettype wire
